// ===== rtl/core/gal_pkg.sv =====
// Package for the grid axis locator: request codes, axis codes, widths and the
// request and response structures between the search sequencer and the divider.
// No dependencies.
package gal_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned OffW      = 16;
  localparam int unsigned FracBits  = 15;
  localparam int unsigned NumW      = 34;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_LOCATE  = 2'd1,
    REQ_REVERSE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    AX_DEPTH = 2'd0,
    AX_LAT   = 2'd1,
    AX_LON   = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_ENDS,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_NEXT_AXIS,
    ST_REV_RD,
    ST_REV_CAP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic signed [NumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [OffW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/gal_divider.sv =====
// Serial signed divider for the cell fraction: (num * 2^15) / den, truncated toward zero.
// One quotient bit per cycle. Depends on gal_pkg.
module gal_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gal_pkg::div_req_t req_i,
  output gal_pkg::div_rsp_t rsp_o
);
  import gal_pkg::*;

  localparam int unsigned DividendW = NumW + FracBits;
  localparam int unsigned CntW      = $clog2(DividendW + 1);

  logic [DividendW-1:0] dvd_q, dvd_d;
  logic [NumW-1:0]      dvs_q, dvs_d;
  logic [NumW:0]        rem_q, rem_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  logic [NumW:0]        rem_sh;
  logic [NumW:0]        rem_sub;
  logic [NumW-1:0]      abs_num;
  logic [NumW-1:0]      abs_den;
  logic [OffW-1:0]      q_mag;

  assign abs_num = req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
  assign abs_den = req_i.den[NumW-1] ? NumW'(-req_i.den) : NumW'(req_i.den);
  assign rem_sh  = {rem_q[NumW-1:0], dvd_q[DividendW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_mag   = dvd_q[OffW-1:0];

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = {abs_num, {FracBits{1'b0}}};
      dvs_d  = abs_den;
      rem_d  = '0;
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
      neg_d  = req_i.num[NumW-1] ^ req_i.den[NumW-1];
    end else if (busy_q) begin
      if (!rem_sub[NumW]) begin
        rem_d = rem_sub;
        dvd_d = {dvd_q[DividendW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? OffW'(-q_mag) : q_mag;

endmodule

// ===== rtl/core/grid_axis_locator_core.sv =====
// Top level of the grid axis locator: three coordinate tables, one search sequencer and
// one serial divider shared by the three axes. Depends on gal_pkg, gal_divider.
// A load writes its entry when accepted; a reverse request reads the three tables and
// registers coordinates and range errors. A locate request takes the axes in turn: it reads
// the first and, for a longer table, the last entry, then clamps to an end or scans and
// divides; the result is registered after the last axis. Reset clears control and counts.
module grid_axis_locator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata from bit 0: req_type, load_axis, load_position, load_value, depth_query,
  // latitude_query, longitude_query, depth_index_in, latitude_index_in,
  // longitude_index_in, zero fill.
  input  logic [175:0]              s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata from bit 0: depth_index_out, latitude_index_out, longitude_index_out,
  // depth_offset, latitude_offset, longitude_offset, depth_coord_out,
  // latitude_coord_out, longitude_coord_out, range_error, zero fill.
  output logic [183:0]              m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [gal_pkg::CountW-1:0] cfg_data_i
);
  import gal_pkg::*;

  logic [CountW-1:0] cnt_q [3];
  logic [1:0]        req_q;
  logic [CoordW-1:0] qry_q [3];
  logic [AddrW-1:0]  rix_q [3];

  logic [CoordW-1:0] mem_d [MaxPoints];
  logic [CoordW-1:0] mem_a [MaxPoints];
  logic [CoordW-1:0] mem_o [MaxPoints];
  logic [CoordW-1:0] rd_q [3];
  logic [AddrW-1:0]  rd_addr [3];

  state_e           st_q, st_d;
  logic [1:0]       ax_q, ax_d;
  logic [AddrW-1:0] i_q, i_d;
  logic signed [CoordW-1:0] first_q, first_d, v0_q, v0_d;
  logic [AddrW-1:0] idx_q [3];
  logic [OffW-1:0]  off_q [3];
  logic [CoordW-1:0] crd_q [3];
  logic [2:0]       err_q, err_d;
  logic             hi_sel_q, hi_sel_d;
  logic             ovalid_q;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic             acc;
  logic [CountW-1:0] n_eff;
  logic signed [CoordW-1:0] cur, t, lo, hi;
  logic signed [NumW-1:0] num, den, an, ad;
  logic             brk;
  logic             set_res;
  logic [AddrW-1:0] res_idx;
  logic             set_off;
  logic [AddrW-1:0] last_i;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= '0;
      cnt_q[1] <= '0;
      cnt_q[2] <= '0;
    end else if (cfg_we_i && cfg_idx_i != 2'd3) begin
      cnt_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q    <= s_axis_tdata[1:0];
      qry_q[0] <= s_axis_tdata[77:46];
      qry_q[1] <= s_axis_tdata[109:78];
      qry_q[2] <= s_axis_tdata[141:110];
      rix_q[0] <= s_axis_tdata[151:142];
      rix_q[1] <= s_axis_tdata[161:152];
      rix_q[2] <= s_axis_tdata[171:162];
    end
  end

  // Three tables, each with a write port for load requests and a registered read port, read one entry a cycle.
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tdata[1:0] == REQ_LOAD) begin
      if (s_axis_tdata[3:2] == AX_DEPTH) mem_d[s_axis_tdata[13:4]] <= s_axis_tdata[45:14];
      if (s_axis_tdata[3:2] == AX_LAT)   mem_a[s_axis_tdata[13:4]] <= s_axis_tdata[45:14];
      if (s_axis_tdata[3:2] == AX_LON)   mem_o[s_axis_tdata[13:4]] <= s_axis_tdata[45:14];
    end
    rd_q[0] <= mem_d[rd_addr[0]];
    rd_q[1] <= mem_a[rd_addr[1]];
    rd_q[2] <= mem_o[rd_addr[2]];
  end

  assign n_eff  = (cnt_q[ax_q] > CountW'(MaxPoints)) ? CountW'(MaxPoints) : cnt_q[ax_q];
  assign last_i = AddrW'(n_eff - 1'b1);
  assign cur    = (ax_q == 2'd3) ? '0 : rd_q[ax_q];
  assign t      = (ax_q == 2'd3) ? '0 : qry_q[ax_q];
  assign lo     = (cur > first_q) ? first_q : cur;
  assign hi     = (cur > first_q) ? cur : first_q;
  assign brk    = (t >= v0_q && t <= cur) || (t <= v0_q && t >= cur);
  assign num    = NumW'(t) - NumW'(v0_q);
  assign den    = NumW'(cur) - NumW'(v0_q);
  assign an     = num[NumW-1] ? -num : num;
  assign ad     = den[NumW-1] ? -den : den;

  always_comb begin
    for (int k = 0; k < 3; k++) rd_addr[k] = i_q;
    if (st_q == ST_REV_RD) begin
      for (int k = 0; k < 3; k++) rd_addr[k] = rix_q[k];
    end else if (st_q == ST_RD_LAST) begin
      for (int k = 0; k < 3; k++) rd_addr[k] = last_i;
    end else if (st_q == ST_SCAN_RD) begin
      for (int k = 0; k < 3; k++) rd_addr[k] = i_q + 1'b1;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc && s_axis_tdata[1:0] == REQ_LOCATE) st_d = ST_RD_FIRST;
        else if (acc && s_axis_tdata[1:0] == REQ_REVERSE) st_d = ST_REV_RD;
      end
      ST_RD_FIRST:  st_d = (n_eff <= CountW'(1)) ? ST_NEXT_AXIS : ST_RD_LAST;
      ST_RD_LAST:   st_d = ST_ENDS;
      ST_ENDS: begin
        if (t <= lo || t >= hi) st_d = ST_NEXT_AXIS;
        else st_d = ST_SCAN_RD;
      end
      ST_SCAN_RD:   st_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (brk) st_d = (den == '0) ? ST_NEXT_AXIS : ST_DIV_START;
        else if (CountW'(i_q) + 1'b1 >= n_eff) st_d = ST_NEXT_AXIS;
        else st_d = ST_SCAN_RD;
      end
      ST_DIV_START: st_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  st_d = drsp.done ? ST_NEXT_AXIS : ST_DIV_WAIT;
      ST_NEXT_AXIS: st_d = (ax_q == AX_LON) ? ST_OUT : ST_RD_FIRST;
      ST_REV_RD:    st_d = ST_REV_CAP;
      ST_REV_CAP:   st_d = ST_OUT;
      ST_OUT:       st_d = ST_IDLE;
      default:      st_d = ST_IDLE;
    endcase
  end

  // Datapath control of the sequencer.
  always_comb begin
    ax_d     = ax_q;
    i_d      = i_q;
    first_d  = first_q;
    v0_d     = v0_q;
    err_d    = err_q;
    hi_sel_d = hi_sel_q;
    set_res  = 1'b0;
    res_idx  = '0;
    set_off  = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = hi_sel_q ? (num - den) : num;
    dreq.den   = den;
    unique case (st_q)
      ST_IDLE: begin
        ax_d  = AX_DEPTH;
        i_d   = '0;
        if (acc) err_d = '0;
      end
      ST_RD_FIRST: begin
        set_res = 1'b1;
        res_idx = '0;
      end
      ST_RD_LAST: first_d = cur;
      ST_ENDS: begin
        if (cur > first_q) begin
          if (first_q >= t) res_idx = '0; else res_idx = last_i;
        end else begin
          if (cur >= t) res_idx = last_i; else res_idx = '0;
        end
        set_res = (cur > first_q) ? (t <= first_q || t >= cur) : (t <= cur || t >= first_q);
        i_d = '0;
      end
      ST_SCAN_RD: begin
        v0_d = cur;
        i_d  = i_q + 1'b1;
      end
      ST_SCAN_CHK: begin
        if (brk) begin
          set_res  = 1'b1;
          hi_sel_d = (an <<< 1) > ad;
          res_idx  = ((an <<< 1) > ad && den != '0) ? i_q : i_q - 1'b1;
        end else begin
          i_d = i_q;
        end
      end
      ST_DIV_START: dreq.start = 1'b1;
      ST_DIV_WAIT: set_off = drsp.done;
      ST_NEXT_AXIS: begin
        ax_d = ax_q + 1'b1;
        i_d  = '0;
      end
      ST_REV_CAP: begin
        for (int k = 0; k < 3; k++) begin
          if (CountW'(rix_q[k]) >= ((cnt_q[k] > CountW'(MaxPoints)) ?
              CountW'(MaxPoints) : cnt_q[k])) err_d[k] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The scan reads entry i while v0 holds entry i-1; the last-read value is tracked
  // by v0 in the scan-read state, so the scan-read state must fetch the next entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ax_q     <= AX_DEPTH;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d;
      if (st_q == ST_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    first_q  <= first_d;
    v0_q     <= v0_d;
    err_q    <= err_d;
    hi_sel_q <= hi_sel_d;
    if (acc) begin
      for (int k = 0; k < 3; k++) begin
        idx_q[k] <= '0;
        off_q[k] <= '0;
        crd_q[k] <= '0;
      end
    end
    if (set_res) begin
      idx_q[ax_q] <= res_idx;
      off_q[ax_q] <= '0;
    end
    if (set_off) off_q[ax_q] <= drsp.quot;
    if (st_q == ST_REV_CAP) begin
      for (int k = 0; k < 3; k++) begin
        crd_q[k] <= (CountW'(rix_q[k]) >= ((cnt_q[k] > CountW'(MaxPoints)) ?
                    CountW'(MaxPoints) : cnt_q[k])) ? '0 : rd_q[k];
      end
    end
  end

  gal_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, (req_q == REQ_REVERSE) ? err_q : 3'b000,
                          crd_q[2], crd_q[1], crd_q[0],
                          off_q[2], off_q[1], off_q[0],
                          idx_q[2], idx_q[1], idx_q[0]};

endmodule

// ===== rtl/core/gal_checker.sv =====
// Port-level checker for grid_axis_locator_core, attached by bind.
// Depends on the top level's port list only.
module gal_props (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata
);

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result waits");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[183:177] == 7'd0)
    else $error("fill bits set");

  a_no_result_at_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result appears right after an accepted request");

endmodule

bind grid_axis_locator_core gal_props u_gal_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/gal_checker.sv =====
`timescale 1ns / 1ps
// Checker for the grid axis locator: watches the request, result and register ports,
// predicts each result from its own copy of the tables and counts, and compares.
// Depends on gal_pkg.
module gal_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [175:0]                s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [183:0]                m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [gal_pkg::CountW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  import gal_pkg::*;

  typedef struct {
    logic [AddrW-1:0]         idx [3];
    logic signed [OffW-1:0]   off [3];
    logic signed [CoordW-1:0] crd [3];
    logic [2:0]               err;
  } grid_result_t;

  logic signed [CoordW-1:0] grid_tbl [3][MaxPoints];
  logic [CountW-1:0]        axis_cnt [3];
  grid_result_t             expected_q [$];

  function automatic int live_count(input int ax);
    return (axis_cnt[ax] > MaxPoints) ? MaxPoints : int'(axis_cnt[ax]);
  endfunction

  function automatic void nearest_point(input int ax, input longint t,
                                        output logic [AddrW-1:0] idx,
                                        output logic signed [OffW-1:0] off);
    int     n;
    bit     asc;
    longint lo, hi, v0, v1, num, den, an, ad, q;
    n = live_count(ax);
    idx = '0;
    off = '0;
    if (n <= 1) return;
    asc = grid_tbl[ax][n-1] > grid_tbl[ax][0];
    lo = asc ? grid_tbl[ax][0] : grid_tbl[ax][n-1];
    hi = asc ? grid_tbl[ax][n-1] : grid_tbl[ax][0];
    if (t <= lo) begin
      idx = asc ? '0 : AddrW'(n - 1);
      return;
    end
    if (t >= hi) begin
      idx = asc ? AddrW'(n - 1) : '0;
      return;
    end
    for (int i = 0; i + 1 < n; i++) begin
      v0 = grid_tbl[ax][i];
      v1 = grid_tbl[ax][i+1];
      if ((t >= v0 && t <= v1) || (t <= v0 && t >= v1)) begin
        num = t - v0;
        den = v1 - v0;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (den == 0) begin
          idx = AddrW'(i);
          return;
        end
        if (2 * an <= ad) begin
          idx = AddrW'(i);
          q = (num * 32768) / den;
        end else begin
          idx = AddrW'(i + 1);
          q = ((num - den) * 32768) / den;
        end
        off = OffW'(q);
        return;
      end
    end
  endfunction

  task automatic report(input string what, input int ax, input longint exp_v,
                        input longint act_v);
    if (fail_count_o < 10)
      $display("Mismatch on %s axis %0d: expected %0d, got %0d", what, ax, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [1:0]   rtype, lax;
    logic [9:0]   kidx;
    grid_result_t r, a;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) axis_cnt[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < 2'd3) axis_cnt[cfg_idx_i] = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        rtype = s_axis_tdata[1:0];
        lax = s_axis_tdata[3:2];
        for (int i = 0; i < 3; i++) begin
          r.idx[i] = '0; r.off[i] = '0; r.crd[i] = '0;
        end
        r.err = '0;
        if (rtype == REQ_LOAD) begin
          if (lax < 2'd3) grid_tbl[lax][s_axis_tdata[13:4]] = s_axis_tdata[45:14];
        end else if (rtype == REQ_LOCATE) begin
          for (int i = 0; i < 3; i++)
            nearest_point(i, longint'($signed(s_axis_tdata[46 + 32*i +: 32])),
                          r.idx[i], r.off[i]);
          expected_q.push_back(r);
        end else if (rtype == REQ_REVERSE) begin
          for (int i = 0; i < 3; i++) begin
            kidx = s_axis_tdata[142 + 10*i +: 10];
            if (int'(kidx) < live_count(i)) r.crd[i] = grid_tbl[i][kidx];
            else r.err[i] = 1'b1;
          end
          expected_q.push_back(r);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        for (int i = 0; i < 3; i++) begin
          a.idx[i] = m_axis_tdata[10*i +: 10];
          a.off[i] = m_axis_tdata[30 + 16*i +: 16];
          a.crd[i] = m_axis_tdata[78 + 32*i +: 32];
        end
        a.err = m_axis_tdata[176:174];
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("Result arrived with nothing expected");
          fail_count_o++;
        end else begin
          r = expected_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (a.idx[i] !== r.idx[i]) report("index", i, r.idx[i], a.idx[i]);
            if (a.off[i] !== r.off[i]) report("offset", i, r.off[i], a.off[i]);
            if (a.crd[i] !== r.crd[i]) report("coordinate", i, r.crd[i], a.crd[i]);
          end
          if (a.err !== r.err) report("range error", 0, r.err, a.err);
          checked_o++;
        end
      end
    end
    pending_o = expected_q.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    checked_o = 0;
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the grid axis locator testbench: clock, reset, stimulus and verdict.
// Depends on gal_pkg, grid_axis_locator_core and gal_checker.
module testbench;
  import gal_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] AX_UNUSED  = 2'd3;
  localparam int         TimeoutCycles = 2000000;
  localparam int         LongAxis = 128;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [175:0]        s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [183:0]        m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CountW-1:0]   cfg_data_i = '0;
  int                  fail_count, pending, checked;
  int                  cycle_cnt = 0;
  int                  burst_left = 0;
  bit                  bursty = 1'b0;
  bit                  hold_req = 1'b0;
  int                  stall_pct = 0;
  int                  n_load = 0, n_locate = 0, n_reverse = 0, n_settings = 0;
  int                  axis_len [3];
  logic signed [31:0]  shadow [3][MaxPoints];

  grid_axis_locator_core dut (.*);

  gal_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > TimeoutCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (3000) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(input logic [1:0] rt, input logic [1:0] ax, input logic [9:0] pos,
                      input logic signed [31:0] val, input logic signed [31:0] q0,
                      input logic signed [31:0] q1, input logic signed [31:0] q2,
                      input logic [9:0] k0, input logic [9:0] k1, input logic [9:0] k2);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, k2, k1, k0, q2, q1, q0, val, pos, ax, rt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (rt == REQ_LOAD) begin
      n_load++;
      if (ax != AX_UNUSED) shadow[ax][pos] = val;
    end else if (rt == REQ_LOCATE) begin
      n_locate++;
    end else if (rt == REQ_REVERSE) begin
      n_reverse++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_counts(input int d, input int la, input int lo);
    axis_len[0] = d; axis_len[1] = la; axis_len[2] = lo;
    for (int i = 0; i < 3; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= CountW'(axis_len[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Fills entries 0..axis_len-1, so no result depends on an unwritten entry.
  task automatic fill_tables(input int span);
    int          shape, step;
    logic [31:0] v;
    for (int ax = 0; ax < 3; ax++) begin
      shape = $urandom_range(4);
      v = (shape == 4) ? $urandom() : $urandom_range(200000) - 100000;
      for (int p = 0; p < axis_len[ax]; p++) begin
        step = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, span);
        case (shape)
          0: v = v + step;
          1: v = v - step;
          2: v = $urandom_range(400000) - 200000;
          3: v = v + (($urandom_range(1)) ? step : 0);
          default: v = $urandom();
        endcase
        send(REQ_LOAD, axis_e'(ax), 10'(p), v, 0, 0, 0, 0, 0, 0);
      end
    end
  endtask

  function automatic logic signed [31:0] pick_query(input int ax);
    int p;
    if (axis_len[ax] == 0 || $urandom_range(5) == 0) return $urandom();
    p = $urandom_range(axis_len[ax] - 1);
    case ($urandom_range(3))
      0: return shadow[ax][p];
      1: return shadow[ax][p] + $signed($urandom_range(8000)) - 4000;
      default: return shadow[ax][p] + $signed($urandom_range(80000)) - 40000;
    endcase
  endfunction

  function automatic logic [9:0] pick_index(input int ax);
    if (axis_len[ax] == 0 || $urandom_range(3) == 0) return 10'($urandom());
    return 10'($urandom_range(axis_len[ax] - 1));
  endfunction

  task automatic random_items(input int cnt);
    int sel;
    for (int j = 0; j < cnt; j++) begin
      sel = $urandom_range(19);
      if (sel < 9)
        send(REQ_LOCATE, 2'($urandom()), 10'($urandom()), $urandom(),
             pick_query(0), pick_query(1), pick_query(2),
             10'($urandom()), 10'($urandom()), 10'($urandom()));
      else if (sel < 15)
        send(REQ_REVERSE, 2'($urandom()), 10'($urandom()), $urandom(),
             $urandom(), $urandom(), $urandom(), pick_index(0), pick_index(1), pick_index(2));
      else if (sel < 18)
        send(REQ_LOAD, 2'($urandom_range(2)), 10'($urandom()), $urandom(),
             $urandom(), $urandom(), $urandom(), 10'($urandom()), 10'($urandom()),
             10'($urandom()));
      else
        send(sel == 18 ? REQ_UNUSED : REQ_LOAD, AX_UNUSED, 10'($urandom()), $urandom(),
             $urandom(), $urandom(), $urandom(), 10'($urandom()), 10'($urandom()),
             10'($urandom()));
    end
  endtask

  task automatic directed_items();
    logic signed [31:0] qmin, qmax;
    qmin = 32'sh8000_0000;
    qmax = 32'sh7FFF_FFFF;
    send(REQ_LOCATE, AX_DEPTH, 0, 0, qmin, qmin, qmin, 0, 0, 0);
    send(REQ_LOCATE, AX_DEPTH, 0, 0, qmax, qmax, qmax, 0, 0, 0);
    send(REQ_LOCATE, AX_DEPTH, 0, 0, shadow[0][0], shadow[1][0], shadow[2][0], 0, 0, 0);
    send(REQ_LOCATE, AX_DEPTH, 0, 0, shadow[0][axis_len[0]-1], shadow[1][axis_len[1]-1],
         shadow[2][axis_len[2]-1], 0, 0, 0);
    for (int p = 0; p + 1 < 3; p++)
      send(REQ_LOCATE, AX_DEPTH, 0, 0, shadow[0][p] + (shadow[0][p+1] - shadow[0][p]) / 2,
           shadow[1][p] + (shadow[1][p+1] - shadow[1][p]) / 2 + 1,
           shadow[2][p] + (shadow[2][p+1] - shadow[2][p]) / 3, 0, 0, 0);
    send(REQ_REVERSE, AX_DEPTH, 0, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_REVERSE, AX_DEPTH, 0, 0, 0, 0, 0, 10'(axis_len[0] - 1),
         10'(axis_len[1] - 1), 10'(axis_len[2] - 1));
    send(REQ_REVERSE, AX_DEPTH, 0, 0, 0, 0, 0, 10'(axis_len[0]), 10'(axis_len[1]),
         10'(axis_len[2]));
    send(REQ_REVERSE, AX_DEPTH, 0, 0, 0, 0, 0, 10'd1023, 10'd1023, 10'd1023);
    send(REQ_UNUSED, AX_DEPTH, 0, 32'sd5, qmax, qmax, qmax, 10'd1023, 10'd1023, 10'd1023);
    send(REQ_LOAD, AX_UNUSED, 10'd0, qmin, 0, 0, 0, 0, 0, 0);
    send(REQ_LOAD, AX_LON, 10'd1023, qmax, 0, 0, 0, 0, 0, 0);
    send(REQ_LOAD, AX_LAT, 10'd512, qmin, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    int settings [6][3] = '{'{0, 0, 0}, '{1, 2, 0}, '{6, 5, 4}, '{2, 1, 9},
                            '{30, 20, 25}, '{17, 6, 40}};
    logic signed [31:0] v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < 6; ph++) begin
      set_counts(settings[ph][0], settings[ph][1], settings[ph][2]);
      bursty = ph[0];
      stall_pct = (ph == 1) ? 0 : 10 * ph;
      fill_tables(ph == 5 ? 30000 : 5000);
      if (ph == 2) directed_items();
      if (ph == 4) begin
        random_items(20);
        hold_req = 1'b1;
      end
      random_items(35);
      drain();
    end
    // Long depth table: ascending with some repeated points.
    set_counts(LongAxis, 0, 1);
    bursty = 1'b0;
    v = 32'sh8000_0000 + 1000;
    for (int p = 0; p < LongAxis; p++) begin
      v = v + 4096 * $urandom_range(3);
      send(REQ_LOAD, AX_DEPTH, 10'(p), v, 0, 0, 0, 0, 0, 0);
    end
    send(REQ_LOAD, AX_LON, 10'd0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    for (int j = 0; j < 10; j++)
      send(REQ_LOCATE, AX_DEPTH, 0, 0, pick_query(0), $urandom(), $urandom(), 0, 0, 0);
    send(REQ_REVERSE, AX_DEPTH, 0, 0, 0, 0, 0, 10'd1023, 10'd0, 10'd0);
    drain();
    $display("Covered %0d loads, %0d locates and %0d reverse lookups over %0d count settings;",
             n_load, n_locate, n_reverse, n_settings);
    $display("%0d results compared, with stalls, bursts and one long output hold-off.",
             checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
